[hw/rtl/bmprle_pkg.sv]
package bmprle_pkg;

   // field widths fixed by the stream format and the register map
   localparam int BYTE_W = 8;
   localparam int NIB_W  = 4;
   localparam int POS_W  = 13;
   localparam int OUT_W  = 12;
   localparam int IDX_W  = 2;

   // nibble masks of a packed rle4 byte
   localparam logic [BYTE_W-1:0] HI_MASK = 8'hF0;
   localparam logic [BYTE_W-1:0] LO_MASK = 8'h0F;

   // escape codes that follow a zero count byte
   localparam logic [BYTE_W-1:0] ESC_EOL   = 8'd0;
   localparam logic [BYTE_W-1:0] ESC_EOB   = 8'd1;
   localparam logic [BYTE_W-1:0] ESC_DELTA = 8'd2;

   // register indexes of the csr port
   localparam logic [IDX_W-1:0] CSR_RLE4_MODE    = 2'd0;
   localparam logic [IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd1;
   localparam logic [IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd2;

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [2:0] {
      PH_COUNT,
      PH_VALUE,
      PH_ESCAPE,
      PH_DX,
      PH_DY,
      PH_ABS,
      PH_PAD
   } bmprle_phase_type;

   // classified stream byte
   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic [NIB_W-1:0]  hi_nib;
      logic [NIB_W-1:0]  lo_nib;
      logic              start_image;
      logic              is_zero;
      logic              esc_eol;
      logic              esc_eob;
      logic              esc_delta;
   } bmprle_word_type;

   // one emitted span
   typedef struct packed {
      logic [OUT_W-1:0]  row_index;
      logic [OUT_W-1:0]  column_start;
      logic [BYTE_W-1:0] pixel_count;
      logic [BYTE_W-1:0] even_pixel;
      logic [BYTE_W-1:0] odd_pixel;
      logic              image_done;
   } bmprle_span_type;

endpackage

[hw/rtl/bmprle_if.sv]
interface bmprle_req_if;
   import bmprle_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              start_image;
   modport source (output valid, output data_byte, output start_image, input ready);
   modport sink (input valid, input data_byte, input start_image, output ready);
endinterface

interface bmprle_rsp_if;
   import bmprle_pkg::*;
   logic              valid;
   logic              ready;
   logic [OUT_W-1:0]  row_index;
   logic [OUT_W-1:0]  column_start;
   logic [BYTE_W-1:0] pixel_count;
   logic [BYTE_W-1:0] even_pixel;
   logic [BYTE_W-1:0] odd_pixel;
   logic              image_done;
   modport source (output valid, output row_index, output column_start,
                   output pixel_count, output even_pixel, output odd_pixel,
                   output image_done, input ready);
   modport sink (input valid, input row_index, input column_start,
                 input pixel_count, input even_pixel, input odd_pixel,
                 input image_done, output ready);
endinterface

interface bmprle_csr_if;
   import bmprle_pkg::*;
   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] index;
   logic [POS_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

[hw/rtl/bmprle_front.sv]
module bmprle_front (
   input  logic                        clock,
   input  logic                        reset,
   bmprle_req_if.sink                  req_port,
   output logic                        word_valid,
   output bmprle_pkg::bmprle_word_type word,
   input  logic                        word_ready
);
   import bmprle_pkg::*;

   logic            stage_valid_ff;
   bmprle_word_type word_ff;
   bmprle_word_type word_in;

   // classify the incoming byte
   always_comb begin
      word_in.data_byte   = req_port.data_byte;
      word_in.hi_nib      = NIB_W'((req_port.data_byte & HI_MASK) >> NIB_W);
      word_in.lo_nib      = NIB_W'(req_port.data_byte & LO_MASK);
      word_in.start_image = req_port.start_image;
      word_in.is_zero     = (req_port.data_byte == ESC_EOL);
      word_in.esc_eol     = (req_port.data_byte == ESC_EOL);
      word_in.esc_eob     = (req_port.data_byte == ESC_EOB);
      word_in.esc_delta   = (req_port.data_byte == ESC_DELTA);
   end

   // input stage, refilled whenever it drains
   assign req_port.ready = !stage_valid_ff || word_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (req_port.ready) begin
         stage_valid_ff <= req_port.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_port.valid && req_port.ready) begin
         word_ff <= word_in;
      end
   end

   assign word_valid = stage_valid_ff;
   assign word       = word_ff;

endmodule

[hw/rtl/bmprle_fifo.sv]
module bmprle_fifo (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push_valid,
   output logic                        push_ready,
   input  bmprle_pkg::bmprle_word_type push_word,
   output logic                        pop_valid,
   input  logic                        pop_ready,
   output bmprle_pkg::bmprle_word_type pop_word
);
   import bmprle_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   bmprle_word_type   mem [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              push;
   logic              pop;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_word   = mem[rd_ptr_ff];

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_word;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count above depth");

   a_pointer_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) || (count_ff == CNT_W'(QUEUE_DEPTH)) |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue pointers disagree with count");

endmodule

[hw/rtl/bmprle_back.sv]
module bmprle_back #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        word_valid,
   input  bmprle_pkg::bmprle_word_type word,
   output logic                        word_ready,
   bmprle_csr_if.sink                  csr_port,
   bmprle_rsp_if.source                rsp_port
);
   import bmprle_pkg::*;

   localparam int POS_MAX = (1 << POS_W) - 1;
   localparam int WCAP    = (MAX_WIDTH > POS_MAX) ? POS_MAX : MAX_WIDTH;
   localparam int HCAP    = (MAX_HEIGHT > POS_MAX) ? POS_MAX : MAX_HEIGHT;

   // configuration
   logic              rle4_ff;
   logic [POS_W-1:0]  width_ff;
   logic [POS_W-1:0]  height_ff;

   // parse state
   bmprle_phase_type  phase_ff, phase_in, cur_phase;
   logic [BYTE_W-1:0] run_ff, run_in, cur_run;
   logic [BYTE_W-1:0] left_ff, left_in, cur_left;
   logic              pad_ff, pad_in, cur_pad;
   logic [POS_W-1:0]  col_ff, col_in, cur_col;
   logic [POS_W-1:0]  row_ff, row_in, cur_row;
   logic [BYTE_W-1:0] dcol_ff, dcol_in, cur_dcol;
   logic              fin_ff, fin_in, cur_fin;

   // result register
   logic              rsp_valid_ff;
   bmprle_span_type   rsp_ff;
   bmprle_span_type   span_in;

   logic              slot_free;
   logic              take;
   logic              emit;
   logic              marker;
   logic              csr_height_wr;
   logic [POS_W-1:0]  eff_w;
   logic [BYTE_W-1:0] span_n;
   logic [BYTE_W-1:0] span_ev;
   logic [BYTE_W-1:0] span_od;
   logic [BYTE_W-1:0] span_cnt;
   logic [POS_W-1:0]  room;
   logic [POS_W:0]    adv_sum;
   logic [POS_W-1:0]  adv_col;
   logic [POS_W:0]    dlt_sum;
   logic [POS_W-1:0]  dlt_col;
   logic [BYTE_W:0]   half_bytes;

   function automatic logic [POS_W-1:0] first_row(input logic [POS_W-1:0] h);
      logic [POS_W-1:0] hc;
      hc = (h > POS_W'(HCAP)) ? POS_W'(HCAP) : h;
      return (hc == '0) ? '0 : hc - 1'b1;
   endfunction

   assign eff_w      = (width_ff > POS_W'(WCAP)) ? POS_W'(WCAP) : width_ff;
   assign slot_free  = !rsp_valid_ff || rsp_port.ready;
   assign word_ready = slot_free;
   assign take       = word_valid && slot_free;

   // height write reloads the row position
   assign csr_height_wr = csr_port.valid && csr_port.ready &&
                          (csr_port.index == CSR_IMAGE_HEIGHT);

   // state as seen by this byte, after an optional restart
   always_comb begin
      if (word.start_image) begin
         cur_phase = PH_COUNT;
         cur_run   = '0;
         cur_left  = '0;
         cur_pad   = 1'b0;
         cur_col   = '0;
         cur_row   = first_row(height_ff);
         cur_dcol  = '0;
         cur_fin   = 1'b0;
      end else begin
         cur_phase = phase_ff;
         cur_run   = run_ff;
         cur_left  = left_ff;
         cur_pad   = pad_ff;
         cur_col   = col_ff;
         cur_row   = row_ff;
         cur_dcol  = dcol_ff;
         cur_fin   = fin_ff;
      end
   end

   // span length and pixel values
   always_comb begin
      if (cur_phase == PH_VALUE) begin
         span_n = cur_run;
      end else if (rle4_ff) begin
         span_n = (cur_left < BYTE_W'(2)) ? cur_left : BYTE_W'(2);
      end else begin
         span_n = BYTE_W'(1);
      end
      if (rle4_ff) begin
         span_ev = BYTE_W'(word.hi_nib);
         span_od = BYTE_W'(word.lo_nib);
      end else begin
         span_ev = word.data_byte;
         span_od = word.data_byte;
      end
   end

   // clipping and column advance
   always_comb begin
      room     = (cur_col < eff_w) ? eff_w - cur_col : '0;
      span_cnt = ((POS_W)'(span_n) < room) ? span_n : room[BYTE_W-1:0];
      adv_sum  = (POS_W+1)'(cur_col) + (POS_W+1)'(span_n);
      adv_col  = (adv_sum > (POS_W+1)'(eff_w)) ? eff_w : adv_sum[POS_W-1:0];
      dlt_sum  = (POS_W+1)'(cur_col) + (POS_W+1)'(cur_dcol);
      dlt_col  = (dlt_sum > (POS_W+1)'(eff_w)) ? eff_w : dlt_sum[POS_W-1:0];
      half_bytes = ((BYTE_W+1)'(word.data_byte) + 1'b1) >> 1;
   end

   // parse step
   always_comb begin
      phase_in = cur_phase;
      run_in   = cur_run;
      left_in  = cur_left;
      pad_in   = cur_pad;
      col_in   = cur_col;
      row_in   = cur_row;
      dcol_in  = cur_dcol;
      fin_in   = cur_fin;
      emit     = 1'b0;
      marker   = 1'b0;
      if (!cur_fin) begin
         unique case (cur_phase)
            PH_COUNT: begin
               if (!word.is_zero) begin
                  run_in   = word.data_byte;
                  phase_in = PH_VALUE;
               end else begin
                  phase_in = PH_ESCAPE;
               end
            end
            PH_VALUE: begin
               phase_in = PH_COUNT;
               emit     = (span_cnt != '0);
               col_in   = adv_col;
               run_in   = '0;
            end
            PH_ESCAPE: begin
               phase_in = PH_COUNT;
               if (word.esc_eol) begin
                  col_in = '0;
                  if (cur_row == '0) begin
                     marker = 1'b1;
                  end else begin
                     row_in = cur_row - 1'b1;
                  end
               end else if (word.esc_eob) begin
                  marker = 1'b1;
               end else if (word.esc_delta) begin
                  phase_in = PH_DX;
               end else begin
                  left_in  = word.data_byte;
                  pad_in   = rle4_ff ? half_bytes[0] : word.data_byte[0];
                  phase_in = PH_ABS;
               end
            end
            PH_DX: begin
               dcol_in  = word.data_byte;
               phase_in = PH_DY;
            end
            PH_DY: begin
               phase_in = PH_COUNT;
               col_in   = dlt_col;
               dcol_in  = '0;
               if (POS_W'(word.data_byte) > cur_row) begin
                  row_in = '0;
                  marker = 1'b1;
               end else begin
                  row_in = cur_row - POS_W'(word.data_byte);
               end
            end
            PH_ABS: begin
               emit    = (span_cnt != '0);
               col_in  = adv_col;
               left_in = cur_left - span_n;
               if (cur_left == span_n) begin
                  phase_in = cur_pad ? PH_PAD : PH_COUNT;
                  pad_in   = 1'b0;
               end
            end
            PH_PAD: begin
               phase_in = PH_COUNT;
            end
            default: begin
               phase_in = PH_COUNT;
            end
         endcase
      end
      if (marker) begin
         fin_in   = 1'b1;
         phase_in = PH_COUNT;
         emit     = 1'b1;
      end
      span_in.row_index    = row_in[OUT_W-1:0];
      span_in.column_start = marker ? col_in[OUT_W-1:0] : cur_col[OUT_W-1:0];
      span_in.pixel_count  = marker ? '0 : span_cnt;
      span_in.even_pixel   = marker ? '0 : span_ev;
      span_in.odd_pixel    = marker ? '0 : span_od;
      span_in.image_done   = marker;
   end

   // state and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rle4_ff   <= 1'b0;
         width_ff  <= POS_W'(1);
         height_ff <= POS_W'(1);
         phase_ff  <= PH_COUNT;
         run_ff    <= '0;
         left_ff   <= '0;
         pad_ff    <= 1'b0;
         col_ff    <= '0;
         row_ff    <= first_row(POS_W'(1));
         dcol_ff   <= '0;
         fin_ff    <= 1'b0;
      end else begin
         if (take) begin
            phase_ff <= phase_in;
            run_ff   <= run_in;
            left_ff  <= left_in;
            pad_ff   <= pad_in;
            col_ff   <= col_in;
            dcol_ff  <= dcol_in;
            fin_ff   <= fin_in;
         end
         if (csr_height_wr) begin
            row_ff <= first_row(csr_port.data);
         end else if (take) begin
            row_ff <= row_in;
         end
         if (csr_port.valid && csr_port.ready) begin
            case (csr_port.index)
               CSR_RLE4_MODE: begin
                  rle4_ff <= csr_port.data[0];
               end
               CSR_IMAGE_WIDTH: begin
                  width_ff <= csr_port.data;
               end
               CSR_IMAGE_HEIGHT: begin
                  height_ff <= csr_port.data;
               end
               default: begin
               end
            endcase
         end
      end
   end

   assign csr_port.ready = 1'b1;

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (slot_free) begin
         rsp_valid_ff <= take && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (take && emit) begin
         rsp_ff <= span_in;
      end
   end

   assign rsp_port.valid        = rsp_valid_ff;
   assign rsp_port.row_index    = rsp_ff.row_index;
   assign rsp_port.column_start = rsp_ff.column_start;
   assign rsp_port.pixel_count  = rsp_ff.pixel_count;
   assign rsp_port.even_pixel   = rsp_ff.even_pixel;
   assign rsp_port.odd_pixel    = rsp_ff.odd_pixel;
   assign rsp_port.image_done   = rsp_ff.image_done;

   a_span_or_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_ff.pixel_count != '0) != rsp_ff.image_done))
      else $error("span word with bad count or done flag");

   a_fin_phase: assert property (@(posedge clock) disable iff (reset)
      fin_ff |-> phase_ff == PH_COUNT)
      else $error("finished decoder left in a mid-code phase");

   a_abs_left: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_ABS |-> left_ff != '0)
      else $error("absolute run with nothing left");

   a_done_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.image_done |-> fin_ff)
      else $error("end marker pending while decoder not finished");

endmodule

[hw/rtl/bmp_rle_decoder_unit.sv]
// path: req -> front input stage -> queue -> result register -> rsp
// throughput: one compressed byte per cycle if rsp is ready; back-end parse and
//   position update are combinational; a two-word queue decouples intake from it
// reset (synchronous): parse state to count byte at row 0 column 0, rle8 mode,
//   image width 1 and height 1; queue and result register emptied
module bmp_rle_decoder_unit #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic         clock,
   input  logic         reset,
   bmprle_req_if.sink   req_port,
   bmprle_rsp_if.source rsp_port,
   bmprle_csr_if.sink   csr_port
);
   import bmprle_pkg::*;

   logic            front_valid;
   logic            front_ready;
   bmprle_word_type front_word;
   logic            back_valid;
   logic            back_ready;
   bmprle_word_type back_word;

   // intake and byte classification
   bmprle_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_port   (req_port),
      .word_valid (front_valid),
      .word       (front_word),
      .word_ready (front_ready)
   );

   // short queue between front and back
   bmprle_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_word  (front_word),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_word   (back_word)
   );

   // parser, position tracking and span output
   bmprle_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .word_valid (back_valid),
      .word       (back_word),
      .word_ready (back_ready),
      .csr_port   (csr_port),
      .rsp_port   (rsp_port)
   );

endmodule

[test/bmp_rle_decoder_unit_tb.sv]
`timescale 1ns / 1ps

module bmp_rle_decoder_unit_tb;
   import bmprle_pkg::*;

   localparam int          MAX_W        = 4096;
   localparam int          MAX_H        = 4096;
   localparam int          PHASES       = 8;
   localparam int          PHASE_ITEMS  = 225;
   localparam int          SETTLE       = 8;
   localparam logic [BYTE_W-1:0] ESCAPE_INTRO = 8'h00;
   localparam logic [IDX_W-1:0]  CSR_UNUSED   = 2'd3;

   typedef struct {
      logic [BYTE_W-1:0] data;
      bit                first;
   } stream_byte_type;

   // decoder state mirror and queue of expected span words
   class span_scoreboard;
      bit                rle4;
      logic [POS_W-1:0]  width_reg;
      logic [POS_W-1:0]  height_reg;
      bmprle_phase_type  phase;
      logic [BYTE_W-1:0] run_len;
      logic [BYTE_W-1:0] abs_left;
      logic [BYTE_W-1:0] dx_pending;
      bit                pad_due;
      bit                done_flag;
      logic [POS_W-1:0]  col;
      logic [POS_W-1:0]  row;
      bmprle_span_type   expected_spans[$];
      int                errors;
      int                spans_seen;
      int                ends_seen;

      function new();
         rle4 = 1'b0;
         width_reg = POS_W'(1);
         height_reg = POS_W'(1);
         errors = 0;
         spans_seen = 0;
         ends_seen = 0;
         restart();
      endfunction

      function int unsigned clip_width();
         return (width_reg > MAX_W) ? MAX_W : width_reg;
      endfunction

      function logic [POS_W-1:0] top_row();
         int unsigned h;
         h = (height_reg > MAX_H) ? MAX_H : height_reg;
         return (h == 0) ? '0 : POS_W'(h - 1);
      endfunction

      function void restart();
         phase = PH_COUNT;
         run_len = '0;
         abs_left = '0;
         dx_pending = '0;
         pad_due = 1'b0;
         done_flag = 1'b0;
         col = '0;
         row = top_row();
      endfunction

      function void write_reg(logic [IDX_W-1:0] idx, logic [POS_W-1:0] val);
         case (idx)
            CSR_RLE4_MODE: rle4 = val[0];
            CSR_IMAGE_WIDTH: width_reg = val;
            CSR_IMAGE_HEIGHT: begin
               height_reg = val;
               row = top_row();
            end
            default: ;
         endcase
      endfunction

      function void push_span(int unsigned cnt, logic [BYTE_W-1:0] ev,
                              logic [BYTE_W-1:0] od, bit last);
         bmprle_span_type s;
         s.row_index = row[OUT_W-1:0];
         s.column_start = col[OUT_W-1:0];
         s.pixel_count = cnt[BYTE_W-1:0];
         s.even_pixel = ev;
         s.odd_pixel = od;
         s.image_done = last;
         expected_spans.push_back(s);
      endfunction

      function void end_of_image();
         done_flag = 1'b1;
         phase = PH_COUNT;
         push_span(0, '0, '0, 1'b1);
      endfunction

      // span at the current position, clipped to the row, then advance
      function void emit_run(int unsigned n, logic [BYTE_W-1:0] ev, logic [BYTE_W-1:0] od);
         int unsigned w;
         int unsigned room;
         int unsigned cnt;
         int unsigned pos;
         w = clip_width();
         room = (col < w) ? w - col : 0;
         cnt = (n < room) ? n : room;
         if (cnt > 0) push_span(cnt, ev, od, 1'b0);
         pos = col + n;
         if (pos > w) pos = w;
         col = pos[POS_W-1:0];
      endfunction

      // returns 0 when the byte is dropped after the end of an image
      function bit note_byte(logic [BYTE_W-1:0] b, bit first);
         logic [BYTE_W-1:0] hi;
         logic [BYTE_W-1:0] lo;
         int unsigned       w;
         int unsigned       pos;
         int unsigned       take;
         int unsigned       nbytes;
         hi = (b & HI_MASK) >> NIB_W;
         lo = b & LO_MASK;
         if (first) restart();
         if (done_flag) return 1'b0;
         case (phase)
            PH_COUNT: begin
               if (b != 0) begin
                  run_len = b;
                  phase = PH_VALUE;
               end else begin
                  phase = PH_ESCAPE;
               end
            end
            PH_VALUE: begin
               phase = PH_COUNT;
               if (rle4) emit_run(run_len, hi, lo);
               else emit_run(run_len, b, b);
               run_len = '0;
            end
            PH_ESCAPE: begin
               phase = PH_COUNT;
               if (b == ESC_EOL) begin
                  col = '0;
                  if (row == 0) end_of_image();
                  else row = row - 1'b1;
               end else if (b == ESC_EOB) begin
                  end_of_image();
               end else if (b == ESC_DELTA) begin
                  phase = PH_DX;
               end else begin
                  nbytes = rle4 ? (int'(b) + 1) >> 1 : int'(b);
                  abs_left = b;
                  pad_due = nbytes[0];
                  phase = PH_ABS;
               end
            end
            PH_DX: begin
               dx_pending = b;
               phase = PH_DY;
            end
            PH_DY: begin
               w = clip_width();
               phase = PH_COUNT;
               pos = col + dx_pending;
               if (pos > w) pos = w;
               col = pos[POS_W-1:0];
               dx_pending = '0;
               if (b > row) begin
                  row = '0;
                  end_of_image();
               end else begin
                  row = row - b;
               end
            end
            PH_ABS: begin
               if (rle4) begin
                  take = (abs_left < 2) ? abs_left : 2;
                  emit_run(take, hi, lo);
               end else begin
                  take = 1;
                  emit_run(1, b, b);
               end
               abs_left = abs_left - BYTE_W'(take);
               if (abs_left == 0) begin
                  phase = pad_due ? PH_PAD : PH_COUNT;
                  pad_due = 1'b0;
               end
            end
            default: phase = PH_COUNT;
         endcase
         return 1'b1;
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned seen);
         if (want != seen) begin
            errors++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, seen);
         end
      endfunction

      function void check_span(bmprle_span_type got);
         bmprle_span_type want;
         if (expected_spans.size() == 0) begin
            errors++;
            $display("%0t: span word with nothing expected, expected none actual row %0d col %0d",
                     $time, got.row_index, got.column_start);
            return;
         end
         want = expected_spans.pop_front();
         compare_field("row_index", want.row_index, got.row_index);
         compare_field("column_start", want.column_start, got.column_start);
         compare_field("pixel_count", want.pixel_count, got.pixel_count);
         compare_field("even_pixel", want.even_pixel, got.even_pixel);
         compare_field("odd_pixel", want.odd_pixel, got.odd_pixel);
         compare_field("image_done", want.image_done, got.image_done);
         if (want.image_done) ends_seen++;
         else spans_seen++;
      endfunction
   endclass

   logic clock;
   logic reset;

   bmprle_req_if req_bus ();
   bmprle_rsp_if rsp_bus ();
   bmprle_csr_if csr_bus ();

   bmp_rle_decoder_unit #(
      .MAX_WIDTH  (MAX_W),
      .MAX_HEIGHT (MAX_H)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus),
      .csr_port (csr_bus)
   );

   span_scoreboard  sb;
   stream_byte_type feed[$];
   bmprle_span_type seen_span;
   bit              idle_en;
   int              items_done;
   int              csr_writes;

   // per-phase register settings, extremes and out-of-range values included
   int unsigned set_mode[PHASES]   = '{1, 0, 1, 0, 1, 0, 1, 0};
   int unsigned set_width[PHASES]  = '{16, 4096, 1, 0, 8191, 37, 300, 9};
   int unsigned set_height[PHASES] = '{6, 4096, 1, 0, 8191, 3, 12, 2};

   always #1 clock = ~clock;

   // result side: random stall bursts while idling is on
   always begin
      @(negedge clock);
      if (!reset && idle_en && $urandom_range(0, 9) == 0) begin
         rsp_bus.ready = 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      rsp_bus.ready = 1'b1;
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         seen_span.row_index = rsp_bus.row_index;
         seen_span.column_start = rsp_bus.column_start;
         seen_span.pixel_count = rsp_bus.pixel_count;
         seen_span.even_pixel = rsp_bus.even_pixel;
         seen_span.odd_pixel = rsp_bus.odd_pixel;
         seen_span.image_done = rsp_bus.image_done;
         sb.check_span(seen_span);
      end
   end

   task automatic send_byte(input logic [BYTE_W-1:0] b, input bit first);
      @(negedge clock);
      if (idle_en && $urandom_range(0, 9) == 0) begin
         req_bus.valid = 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.data_byte = b;
      req_bus.start_image = first;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      if (sb.note_byte(b, first)) items_done++;
   endtask

   task automatic write_csr(input logic [IDX_W-1:0] idx, input logic [POS_W-1:0] val);
      @(negedge clock);
      csr_bus.valid = 1'b1;
      csr_bus.index = idx;
      csr_bus.data = val;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      sb.write_reg(idx, val);
      csr_writes++;
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   // stop input, wait for every expected word, then let the pipe settle
   task automatic drain();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (sb.expected_spans.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic stream_feed();
      stream_byte_type sb_word;
      while (feed.size() != 0) begin
         sb_word = feed.pop_front();
         send_byte(sb_word.data, sb_word.first);
      end
   endtask

   function automatic void add_byte(logic [BYTE_W-1:0] b, bit first);
      stream_byte_type w;
      w.data = b;
      w.first = first;
      feed.push_back(w);
   endfunction

   // one image worth of commands, mostly well formed with some noise
   function automatic void build_image(bit fresh, bit nib_mode);
      int unsigned ncmd;
      int unsigned pick;
      int unsigned n;
      int unsigned nbytes;
      ncmd = $urandom_range(3, 24);
      add_byte(ESCAPE_INTRO, fresh);
      add_byte(8'($urandom_range(0, 1) ? ESC_EOL : ESC_DELTA + 1), 1'b0);
      for (int i = 0; i < ncmd; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            // encoded run
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 20);
            add_byte(8'(n), 1'b0);
            add_byte(8'($urandom), 1'b0);
         end else if (pick < 60) begin
            // absolute run, padded to a 16-bit boundary
            n = ($urandom_range(0, 15) == 0) ? $urandom_range(3, 255) : $urandom_range(3, 10);
            nbytes = nib_mode ? (n + 1) >> 1 : n;
            add_byte(ESCAPE_INTRO, 1'b0);
            add_byte(8'(n), 1'b0);
            repeat (nbytes) add_byte(8'($urandom), 1'b0);
            if (nbytes[0]) add_byte(8'($urandom), 1'b0);
         end else if (pick < 75) begin
            add_byte(ESCAPE_INTRO, 1'b0);
            add_byte(ESC_EOL, 1'b0);
         end else if (pick < 85) begin
            add_byte(ESCAPE_INTRO, 1'b0);
            add_byte(ESC_DELTA, 1'b0);
            add_byte(8'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 6)), 1'b0);
            add_byte(8'($urandom_range(0, 5) == 0 ? $urandom : $urandom_range(0, 2)), 1'b0);
         end else if (pick < 93) begin
            // raw noise, now and then restarting the image
            repeat ($urandom_range(1, 3))
               add_byte(8'($urandom), $urandom_range(0, 7) == 0);
         end else begin
            // stray escape that throws the command framing off
            add_byte(ESCAPE_INTRO, 1'b0);
         end
      end
      if ($urandom_range(0, 4) != 0) begin
         add_byte(ESCAPE_INTRO, 1'b0);
         add_byte(ESC_EOB, 1'b0);
      end
   endfunction

   initial begin
      int start_count;
      clock = 1'b0;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.data_byte = '0;
      req_bus.start_image = 1'b0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = '0;
      csr_bus.data = '0;
      idle_en = 1'b1;
      items_done = 0;
      csr_writes = 0;
      sb = new();

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: rle8, 8 pixels wide, 4 rows
      write_csr(CSR_UNUSED, 13'($urandom));
      write_csr(CSR_RLE4_MODE, '0);
      write_csr(CSR_IMAGE_WIDTH, 13'd8);
      write_csr(CSR_IMAGE_HEIGHT, 13'd4);
      // long run clipped to the row
      add_byte(8'hFF, 1'b1);
      add_byte(8'hFF, 1'b0);
      add_byte(ESCAPE_INTRO, 1'b0);
      add_byte(ESC_EOL, 1'b0);
      add_byte(8'h01, 1'b0);
      add_byte(8'h00, 1'b0);
      // delta past the right edge, then a run clipped away entirely
      add_byte(ESCAPE_INTRO, 1'b0);
      add_byte(ESC_DELTA, 1'b0);
      add_byte(8'hFF, 1'b0);
      add_byte(8'h01, 1'b0);
      add_byte(8'h05, 1'b0);
      add_byte(8'h12, 1'b0);
      add_byte(ESCAPE_INTRO, 1'b0);
      add_byte(ESC_EOL, 1'b0);
      // odd absolute run with its pad byte
      add_byte(ESCAPE_INTRO, 1'b0);
      add_byte(8'h03, 1'b0);
      add_byte(8'hA5, 1'b0);
      add_byte(8'h5A, 1'b0);
      add_byte(8'h3C, 1'b0);
      add_byte(8'h77, 1'b0);
      // delta below row 0 ends the image, next byte is dropped
      add_byte(ESCAPE_INTRO, 1'b0);
      add_byte(ESC_DELTA, 1'b0);
      add_byte(8'h00, 1'b0);
      add_byte(8'h05, 1'b0);
      add_byte(8'h99, 1'b0);
      // restart and end of bitmap
      add_byte(ESCAPE_INTRO, 1'b1);
      add_byte(ESC_EOB, 1'b0);
      stream_feed();

      // random images under each register setting
      for (int p = 0; p < PHASES; p++) begin
         drain();
         write_csr(CSR_RLE4_MODE, POS_W'(set_mode[p]));
         write_csr(CSR_IMAGE_WIDTH, POS_W'(set_width[p]));
         write_csr(CSR_IMAGE_HEIGHT, POS_W'(set_height[p]));
         idle_en = (p == PHASES - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
         start_count = items_done;
         // first image may carry on from the state left by the last phase
         build_image($urandom_range(0, 3) != 0, set_mode[p][0]);
         stream_feed();
         while (items_done - start_count < PHASE_ITEMS) begin
            build_image(1'b1, set_mode[p][0]);
            stream_feed();
         end
      end

      drain();
      $display("covered %0d decoded bytes, %0d register writes, %0d pixel spans, %0d image ends",
               items_done, csr_writes, sb.spans_seen, sb.ends_seen);
      $display("mismatches: %0d", sb.errors);
      if (sb.errors == 0) begin
         $display("bmp_rle_decoder_unit_tb OK");
      end else begin
         $display("bmp_rle_decoder_unit_tb NOT OK");
      end
      $finish;
   end

   // watchdog
   initial begin
      #1500000;
      $display("bmp_rle_decoder_unit_tb NOT OK");
      $finish;
   end

endmodule

[bmp_rle_decoder_unit.f]
hw/rtl/bmprle_pkg.sv
hw/rtl/bmprle_if.sv
hw/rtl/bmprle_front.sv
hw/rtl/bmprle_fifo.sv
hw/rtl/bmprle_back.sv
hw/rtl/bmp_rle_decoder_unit.sv
test/bmp_rle_decoder_unit_tb.sv
